### hw/rtl/hrs_pkg.sv
// Shared constants and codes for the histogram rank select block.
`default_nettype none

package hrs_pkg;

	// Histogram geometry: counters are packed several to a memory row.
	localparam int NUM_VALUES  = 256;
	localparam int COUNT_WIDTH = 4;
	localparam int LANES       = 8;
	localparam int ROWS        = NUM_VALUES / LANES;
	localparam int LANE_W      = $clog2(LANES);
	localparam int ROW_W       = $clog2(ROWS);
	localparam int WORD_W      = LANES * COUNT_WIDTH;
	localparam int TOTAL_W     = $clog2(NUM_VALUES * ((1 << COUNT_WIDTH) - 1) + 1);

	// Field and register widths.
	localparam int VALUE_W   = 8;
	localparam int FUNC_W    = 3;
	localparam int STATUS_W  = 3;
	localparam int OCC_W     = 4;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_W     = 8;

	typedef enum logic [FUNC_W-1:0] {
		OP_INSERT = 3'd0,
		OP_REMOVE = 3'd1,
		OP_CLEAR  = 3'd2,
		OP_READ   = 3'd3,
		OP_SELECT = 3'd4
	} func_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 3'd0,
		ST_RANGE = 3'd1,
		ST_OVER  = 3'd2,
		ST_UNDER = 3'd3,
		ST_FEW   = 3'd4
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MAX_VALUE = 2'd0,
		REG_OCC_LIMIT = 2'd1,
		REG_RANK      = 2'd2
	} cfg_reg_t;

endpackage

`default_nettype wire

### hw/rtl/histogram_rank_select.sv
// Histogram rank select: packed counter RAM with a read-modify-write sequencer.
//
// One input beat (func, value) is one operation on a histogram of 256 4-bit
// counters; every input beat yields exactly one output beat (result_value,
// status). Both channels use valid/ready. The configuration port (cfg_we,
// cfg_index, cfg_wdata) writes one register per cycle, chosen by cfg_index:
// the value limit, the occurrence limit or the rank.
// The counters live in a 32-row RAM, eight counters per row, with a
// registered read port, so a row arrives the cycle after its address.
// Insert, remove, clear and read on a value in range take one RAM read, and
// a changed counter is written back in S_LOOK before S_DONE loads the output.
// Select walks the rows one per cycle and adds the eight counters of a row
// in that cycle; it stops at the row where the total reaches the rank, or after the last row.
// The block works on one operation at a time and accepts a new input beat
// once the previous result has moved into the output register.
// Reset clears a valid bit per RAM row, so every counter reads zero right
// after reset with no clearing pass; configuration returns to 255, 9 and 5.
// When the receiver stalls, the result waits in the output register; one
// more finished result waits in the sequencer, which then holds off input.
`default_nettype none

module histogram_rank_select (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	output logic                                 in_ready,
	input  wire logic [hrs_pkg::FUNC_W-1:0]      func,
	input  wire logic [hrs_pkg::VALUE_W-1:0]     value,
	output logic                                 out_valid,
	input  wire logic                            out_ready,
	output logic      [hrs_pkg::VALUE_W-1:0]     result_value,
	output logic      [hrs_pkg::STATUS_W-1:0]    status,
	input  wire logic                            cfg_we,
	input  wire logic [hrs_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [hrs_pkg::CFG_W-1:0]       cfg_wdata
);

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_LOOK = 4'b0010,
		S_SCAN = 4'b0100,
		S_DONE = 4'b1000
	} state_t;

	state_t state_q, state_d;

	// Configuration registers.
	logic [hrs_pkg::VALUE_W-1:0] max_value_q;
	logic [hrs_pkg::OCC_W-1:0]   max_occ_q;
	logic [hrs_pkg::VALUE_W-1:0] rank_q;

	// Operation in flight.
	hrs_pkg::func_t                func_s1;
	logic [hrs_pkg::VALUE_W-1:0]   value_s1;
	logic [hrs_pkg::ROW_W-1:0]     scan_q;
	logic [hrs_pkg::TOTAL_W-1:0]   total_q;
	logic [hrs_pkg::VALUE_W-1:0]   res_q, res_d;
	hrs_pkg::status_t              st_q, st_d;

	// Output register.
	logic                          out_valid_q;
	logic [hrs_pkg::VALUE_W-1:0]   result_q;
	hrs_pkg::status_t              status_q;
	logic                          load_out;

	// Counter RAM and per-row valid bits.
	logic                          ram_we;
	logic [hrs_pkg::ROW_W-1:0]     ram_waddr, ram_raddr;
	logic [hrs_pkg::WORD_W-1:0]    ram_wdata, ram_rdata;
	logic [hrs_pkg::ROWS-1:0]      row_vld_q;
	logic                          rvld_s1;
	logic [hrs_pkg::WORD_W-1:0]    row_data;

	// Single-counter update.
	logic [hrs_pkg::LANE_W-1:0]      look_lane;
	logic [hrs_pkg::COUNT_WIDTH-1:0] look_cnt, look_new;
	logic                            look_we;
	logic [hrs_pkg::VALUE_W-1:0]     look_res;
	hrs_pkg::status_t                look_st;
	logic [hrs_pkg::WORD_W-1:0]      look_wdata;

	// Row scan.
	logic [hrs_pkg::TOTAL_W-1:0] scan_total;
	logic                        scan_hit;
	logic [hrs_pkg::LANE_W-1:0]  scan_lane;

	logic accept;
	logic out_of_range;

	assign in_ready     = (state_q == S_IDLE);
	assign accept       = in_valid && in_ready;
	assign out_of_range = (value > max_value_q) || (int'(value) >= hrs_pkg::NUM_VALUES);

	hrs_ram #(
		.WIDTH (hrs_pkg::WORD_W),
		.DEPTH (hrs_pkg::ROWS)
	) u_count_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// A row never written reads as all-zero counts.
	assign row_data = rvld_s1 ? ram_rdata : '0;

	// Read-modify-write of one counter.
	always_comb begin
		look_lane = value_s1[hrs_pkg::LANE_W-1:0];
		look_cnt  = row_data[look_lane*hrs_pkg::COUNT_WIDTH +: hrs_pkg::COUNT_WIDTH];
		look_new  = look_cnt;
		look_we   = 1'b0;
		look_res  = '0;
		look_st   = hrs_pkg::ST_OK;
		case (func_s1)
			hrs_pkg::OP_INSERT: begin
				if (({1'b0, look_cnt} + 5'd1) > {1'b0, max_occ_q}) begin
					look_st = hrs_pkg::ST_OVER;
				end else begin
					look_new = look_cnt + 1'b1;
					look_we  = 1'b1;
				end
			end
			hrs_pkg::OP_REMOVE: begin
				if (look_cnt == '0) begin
					look_st = hrs_pkg::ST_UNDER;
				end else begin
					look_new = look_cnt - 1'b1;
					look_we  = 1'b1;
				end
			end
			hrs_pkg::OP_CLEAR: begin
				look_new = '0;
				look_we  = 1'b1;
			end
			hrs_pkg::OP_READ: begin
				look_res = hrs_pkg::VALUE_W'(look_cnt);
			end
			default: begin
				look_we = 1'b0;
			end
		endcase
		for (int l = 0; l < hrs_pkg::LANES; l++) begin
			look_wdata[l*hrs_pkg::COUNT_WIDTH +: hrs_pkg::COUNT_WIDTH] =
				(hrs_pkg::LANE_W'(l) == look_lane) ? look_new :
				row_data[l*hrs_pkg::COUNT_WIDTH +: hrs_pkg::COUNT_WIDTH];
		end
	end

	// Running total across one row; first lane whose prefix reaches the rank.
	always_comb begin
		scan_total = total_q;
		scan_hit   = 1'b0;
		scan_lane  = '0;
		for (int l = 0; l < hrs_pkg::LANES; l++) begin
			scan_total = scan_total +
				hrs_pkg::TOTAL_W'(row_data[l*hrs_pkg::COUNT_WIDTH +: hrs_pkg::COUNT_WIDTH]);
			if (!scan_hit && (scan_total >= hrs_pkg::TOTAL_W'(rank_q))) begin
				scan_hit  = 1'b1;
				scan_lane = hrs_pkg::LANE_W'(l);
			end
		end
	end

	// Sequencer.
	always_comb begin
		state_d   = state_q;
		res_d     = res_q;
		st_d      = st_q;
		ram_we    = 1'b0;
		ram_waddr = value_s1[hrs_pkg::LANE_W +: hrs_pkg::ROW_W];
		ram_wdata = look_wdata;
		ram_raddr = '0;
		load_out  = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				ram_raddr = value[hrs_pkg::LANE_W +: hrs_pkg::ROW_W];
				if (accept) begin
					unique case (hrs_pkg::func_t'(func)) inside
						hrs_pkg::OP_INSERT, hrs_pkg::OP_REMOVE,
						hrs_pkg::OP_CLEAR, hrs_pkg::OP_READ: begin
							if (out_of_range) begin
								res_d   = '0;
								st_d    = hrs_pkg::ST_RANGE;
								state_d = S_DONE;
							end else begin
								state_d = S_LOOK;
							end
						end
						hrs_pkg::OP_SELECT: begin
							ram_raddr = '0;
							if (rank_q == '0) begin
								res_d   = '0;
								st_d    = hrs_pkg::ST_FEW;
								state_d = S_DONE;
							end else begin
								state_d = S_SCAN;
							end
						end
						default: begin
							res_d   = '0;
							st_d    = hrs_pkg::ST_OK;
							state_d = S_DONE;
						end
					endcase
				end
			end
			S_LOOK: begin
				ram_we  = look_we;
				res_d   = look_res;
				st_d    = look_st;
				state_d = S_DONE;
			end
			S_SCAN: begin
				ram_raddr = scan_q + 1'b1;
				if (scan_hit) begin
					res_d   = hrs_pkg::VALUE_W'({scan_q, scan_lane});
					st_d    = hrs_pkg::ST_OK;
					state_d = S_DONE;
				end else if (scan_q == hrs_pkg::ROW_W'(hrs_pkg::ROWS - 1)) begin
					res_d   = '0;
					st_d    = hrs_pkg::ST_FEW;
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (!out_valid_q || out_ready) begin
					load_out = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			row_vld_q   <= '0;
			rvld_s1     <= 1'b0;
			max_value_q <= 8'd255;
			max_occ_q   <= 4'd9;
			rank_q      <= 8'd5;
		end else begin
			state_q <= state_d;
			rvld_s1 <= row_vld_q[ram_raddr];
			if (ram_we) begin
				row_vld_q[ram_waddr] <= 1'b1;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				case (hrs_pkg::cfg_reg_t'(cfg_index))
					hrs_pkg::REG_MAX_VALUE: max_value_q <= cfg_wdata;
					hrs_pkg::REG_OCC_LIMIT: max_occ_q   <= cfg_wdata[hrs_pkg::OCC_W-1:0];
					hrs_pkg::REG_RANK:      rank_q      <= cfg_wdata;
					default:                max_value_q <= max_value_q;
				endcase
			end
		end
	end

	// Payload of the operation in flight and of the output beat.
	always_ff @(posedge clk) begin
		res_q <= res_d;
		st_q  <= st_d;
		if (accept) begin
			func_s1  <= hrs_pkg::func_t'(func);
			value_s1 <= value;
			scan_q   <= '0;
			total_q  <= '0;
		end else if (state_q == S_SCAN) begin
			scan_q  <= scan_q + 1'b1;
			total_q <= scan_total;
		end
		if (load_out) begin
			result_q <= res_q;
			status_q <= st_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign result_value = result_q;
	assign status       = status_q;

	// The counter RAM is only written by a single-counter update.
	a_write_in_look: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == S_LOOK))
		else $error("counter RAM written outside the update step");

	// Only a select walks the rows.
	a_scan_is_select: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> (func_s1 == hrs_pkg::OP_SELECT))
		else $error("row scan running for an operation other than select");

	// An accepted beat always starts work.
	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q != S_IDLE))
		else $error("accepted beat left the sequencer idle");

	// Every failed operation returns a zero result.
	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (status != hrs_pkg::ST_OK)) |-> (result_value == '0))
		else $error("nonzero result on an error beat");

endmodule

`default_nettype wire

### hw/rtl/hrs_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
`default_nettype none

module hrs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

### verif/histogram_rank_select_checker.sv
// Checker for histogram_rank_select: predicts every result beat and compares it.
module histogram_rank_select_checker
	import hrs_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 in_ready,
	input  logic [FUNC_W-1:0]    func,
	input  logic [VALUE_W-1:0]   value,
	input  logic                 out_valid,
	input  logic                 out_ready,
	input  logic [VALUE_W-1:0]   result_value,
	input  logic [STATUS_W-1:0]  status,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_wdata,
	output int                   fail_count,
	output int                   outstanding
);

	typedef struct packed {
		logic [VALUE_W-1:0] result_value;
		status_t            status;
	} outcome_t;

	// Shadow copy of the histogram and of the configuration registers.
	logic [COUNT_WIDTH-1:0] bin_count [NUM_VALUES];
	logic [VALUE_W-1:0]     cfg_max_value;
	logic [OCC_W-1:0]       cfg_max_occ;
	logic [VALUE_W-1:0]     cfg_rank;
	outcome_t               expected_beats [$];

	assign outstanding = expected_beats.size();

	// Apply one operation to the shadow histogram and return the result it gives.
	function automatic outcome_t predict_histogram_op(input logic [FUNC_W-1:0] op,
			input logic [VALUE_W-1:0] sample);
		outcome_t               o;
		logic [COUNT_WIDTH-1:0] c;
		int                     running;
		o.result_value = '0;
		o.status       = ST_OK;
		c              = bin_count[sample];
		running        = 0;
		if (op <= OP_READ && sample > cfg_max_value) begin
			o.status = ST_RANGE;
		end else begin
			case (op)
				OP_INSERT: begin
					// The counter limit is the register, which as a 4-bit field can never
					// exceed 15, the largest count a 4-bit counter holds.
					if (c >= cfg_max_occ)
						o.status = ST_OVER;
					else
						bin_count[sample] = c + 1'b1;
				end
				OP_REMOVE: begin
					if (c == '0)
						o.status = ST_UNDER;
					else
						bin_count[sample] = c - 1'b1;
				end
				OP_CLEAR: bin_count[sample] = '0;
				OP_READ: o.result_value = VALUE_W'(c);
				OP_SELECT: begin
					// Walk the bins upward, all of them, until the running total
					// reaches the rank; a rank of zero never matches.
					o.status = ST_FEW;
					if (cfg_rank != '0) begin
						for (int i = 0; i < NUM_VALUES; i++) begin
							running += bin_count[i];
							if (running >= cfg_rank && o.status == ST_FEW) begin
								o.result_value = VALUE_W'(i);
								o.status       = ST_OK;
							end
						end
					end
				end
				default: ;
			endcase
		end
		return o;
	endfunction

	// Track configuration writes and input beats, and check each output beat.
	always @(posedge clk or negedge arst_n) begin
		outcome_t want;
		if (!arst_n) begin
			foreach (bin_count[i])
				bin_count[i] = '0;
			cfg_max_value = 8'd255;
			cfg_max_occ   = 4'd9;
			cfg_rank      = 8'd5;
			expected_beats.delete();
			fail_count = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_MAX_VALUE: cfg_max_value = cfg_wdata[VALUE_W-1:0];
					REG_OCC_LIMIT: cfg_max_occ = cfg_wdata[OCC_W-1:0];
					REG_RANK:      cfg_rank = cfg_wdata[VALUE_W-1:0];
					default: ;
				endcase
			end
			if (in_valid && in_ready)
				expected_beats.push_back(predict_histogram_op(func, value));
			if (out_valid && out_ready) begin
				if (expected_beats.size() == 0) begin
					$display("%0t: result beat expected none, actual result_value %0d status %0d",
						$time, result_value, status);
					fail_count++;
				end else begin
					want = expected_beats.pop_front();
					if (result_value !== want.result_value) begin
						$display("%0t: result_value expected %0d actual %0d",
							$time, want.result_value, result_value);
						fail_count++;
					end
					if (status !== want.status) begin
						$display("%0t: status expected %0d actual %0d",
							$time, want.status, status);
						fail_count++;
					end
				end
			end
		end
	end

endmodule

### verif/histogram_rank_select_tb.sv
// Testbench top for histogram_rank_select: drives operations and registers, gives the verdict.
module histogram_rank_select_tb;
	import hrs_pkg::*;

	localparam int PHASES        = 12;
	localparam int PHASE_ITEMS   = 150;
	localparam int CYCLE_LIMIT   = 500000;
	localparam int SETTLE_CYCLES = 40;

	// Register index with no register behind it, and the unused operation codes.
	localparam logic [CFG_IDX_W-1:0] REG_SPARE      = 2'd3;
	localparam logic [FUNC_W-1:0]    OP_SPARE_FIRST = 3'd5;
	localparam logic [FUNC_W-1:0]    OP_SPARE_LAST  = 3'd7;

	logic                 clk          = 1'b0;
	logic                 arst_n       = 1'b0;
	logic                 in_valid     = 1'b0;
	logic                 in_ready;
	logic [FUNC_W-1:0]    func         = '0;
	logic [VALUE_W-1:0]   value        = '0;
	logic                 out_valid;
	logic                 out_ready    = 1'b0;
	logic [VALUE_W-1:0]   result_value;
	logic [STATUS_W-1:0]  status;
	logic                 cfg_we       = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index    = '0;
	logic [CFG_W-1:0]     cfg_wdata    = '0;

	int fail_count;
	int outstanding;
	int sent     = 0;
	int received = 0;
	int cycles   = 0;
	bit quiet    = 1'b0;

	histogram_rank_select uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.func         (func),
		.value        (value),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.result_value (result_value),
		.status       (status),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata)
	);

	histogram_rank_select_checker u_hist_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.func         (func),
		.value        (value),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.result_value (result_value),
		.status       (status),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.fail_count   (fail_count),
		.outstanding  (outstanding)
	);

	always #1 clk = ~clk;

	// Count result beats and guard against a hang.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (out_valid && out_ready)
			received <= received + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("histogram_rank_select regression: fail");
			$finish;
		end
	end

	// Receiver: random stall bursts, none once the quiet tail starts.
	initial begin
		@(posedge arst_n);
		forever begin
			if (!quiet && $urandom_range(0, 2) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 7)) @(posedge clk);
			end
			out_ready <= 1'b1;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
	end

	// Offer one operation beat, maybe after a gap, and wait until it is taken.
	task automatic send_op(input logic [FUNC_W-1:0] op, input logic [VALUE_W-1:0] sample);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		in_valid <= 1'b1;
		func     <= op;
		value    <= sample;
		do
			@(posedge clk);
		while (!in_ready);
		sent++;
	endtask

	// Stop offering beats and wait until every result is back.
	task automatic drain();
		in_valid <= 1'b0;
		while (received != sent)
			@(posedge clk);
	endtask

	// Write all three registers, then the unused index, on consecutive cycles.
	task automatic set_config(input logic [7:0] max_val, input logic [3:0] max_occ,
			input logic [7:0] rank_sel);
		logic [3:0] upper;
		upper = 4'($urandom_range(0, 15));
		cfg_we    <= 1'b1;
		cfg_index <= REG_MAX_VALUE;
		cfg_wdata <= max_val;
		@(posedge clk);
		cfg_index <= REG_OCC_LIMIT;
		cfg_wdata <= {upper, max_occ};
		@(posedge clk);
		cfg_index <= REG_RANK;
		cfg_wdata <= rank_sel;
		@(posedge clk);
		cfg_index <= REG_SPARE;
		cfg_wdata <= CFG_W'($urandom);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin : stimulus
		int                 mv;
		int                 mo;
		int                 rk;
		int                 ins_pct;
		int                 base;
		int                 pick;
		logic [FUNC_W-1:0]  op;
		logic [VALUE_W-1:0] sample;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: limit of two per value, values up to 200, rank three.
		set_config(8'd200, 4'd2, 8'd3);
		send_op(OP_SELECT, 8'd0);       // empty histogram has too few entries
		send_op(OP_REMOVE, 8'd0);       // removing from a zero count
		send_op(OP_READ, 8'd0);
		send_op(OP_INSERT, 8'd0);
		send_op(OP_INSERT, 8'd0);
		send_op(OP_INSERT, 8'd0);       // past the occurrence limit
		send_op(OP_INSERT, 8'd200);     // largest accepted value
		send_op(OP_INSERT, 8'd201);     // just above the value limit
		send_op(OP_INSERT, 8'd255);
		send_op(OP_READ, 8'd0);
		send_op(OP_SELECT, 8'd255);     // third entry sits at 200
		send_op(OP_SPARE_FIRST, 8'd0);  // unknown operations are ignored
		send_op(OP_SPARE_LAST, 8'd255);
		send_op(OP_CLEAR, 8'd0);
		send_op(OP_SELECT, 8'd0);       // one entry left, too few
		send_op(OP_REMOVE, 8'd200);
		send_op(OP_CLEAR, 8'd255);
		drain();

		// Rank zero never selects anything.
		set_config(8'd255, 4'd15, 8'd0);
		send_op(OP_INSERT, 8'd255);
		send_op(OP_SELECT, 8'd0);
		drain();

		// Select still scans bins above a lowered value limit.
		set_config(8'd10, 4'd15, 8'd1);
		send_op(OP_SELECT, 8'd0);
		send_op(OP_REMOVE, 8'd255);
		send_op(OP_READ, 8'd255);
		drain();

		// Random phases, each under its own register setting.
		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: begin mv = 255; mo = 15; rk = 1;   ins_pct = 75; end
				1: begin mv = 255; mo = 15; rk = 128; ins_pct = 75; end
				2: begin mv = 255; mo = 15; rk = 255; ins_pct = 55; end
				3: begin mv = 40;  mo = 15; rk = 20;  ins_pct = 40; end
				4: begin mv = 0;   mo = 1;  rk = 1;   ins_pct = 45; end
				5: begin mv = 255; mo = 0;  rk = 3;   ins_pct = 40; end
				6: begin mv = 255; mo = 9;  rk = 5;   ins_pct = 25; end
				default: begin
					mv      = $urandom_range(0, 255);
					mo      = $urandom_range(1, 15);
					rk      = $urandom_range(1, 40);
					ins_pct = $urandom_range(30, 60);
				end
			endcase
			set_config(mv[7:0], mo[3:0], rk[7:0]);
			quiet = (ph >= PHASES - 2);
			base  = $urandom_range(0, mv);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				// Half the samples from a narrow window so counts build up and saturate.
				pick = $urandom_range(0, 99);
				if (pick < 50)
					sample = VALUE_W'(base + $urandom_range(0, 7));
				else if (pick < 85)
					sample = VALUE_W'($urandom_range(0, mv));
				else
					sample = VALUE_W'($urandom_range(0, 255));
				if ($urandom_range(0, 99) < ins_pct) begin
					op = OP_INSERT;
				end else begin
					pick = $urandom_range(0, 19);
					if (pick < 7)
						op = OP_REMOVE;
					else if (pick < 11)
						op = OP_READ;
					else if (pick < 17)
						op = OP_SELECT;
					else if (pick < 18)
						op = OP_CLEAR;
					else
						op = FUNC_W'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
				end
				send_op(op, sample);
			end
			drain();
		end

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fail_count == 0 && outstanding == 0)
			$display("histogram_rank_select regression: pass");
		else
			$display("histogram_rank_select regression: fail");
		$finish;
	end

endmodule

### sim.f
hw/rtl/hrs_pkg.sv
hw/rtl/hrs_ram.sv
hw/rtl/histogram_rank_select.sv
verif/histogram_rank_select_checker.sv
verif/histogram_rank_select_tb.sv
